// ===== rtl/tssc_pkg.sv =====
// Shared types, constants and the CRC-8 byte update for the scratchpad checker.
package tssc_pkg;

  localparam int unsigned PosWidth = 4;

  // Scratchpad byte positions
  localparam logic [PosWidth-1:0] POS_TEMP_LOW  = 4'd0;
  localparam logic [PosWidth-1:0] POS_TEMP_HIGH = 4'd1;
  localparam logic [PosWidth-1:0] POS_CONFIG    = 4'd4;
  localparam logic [PosWidth-1:0] POS_CRC       = 4'd8;

  localparam logic [7:0] CrcFeedback = 8'h8C;
  localparam int unsigned ResShift   = 5;

  // Resolution codes
  localparam logic [1:0] RES_9BIT  = 2'd0;
  localparam logic [1:0] RES_10BIT = 2'd1;
  localparam logic [1:0] RES_11BIT = 2'd2;
  localparam logic [1:0] RES_12BIT = 2'd3;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       frame_start;
  } in_item_t;

  typedef struct packed {
    logic signed [11:0] temperature_sixteenths;
    logic [1:0]         resolution_code;
    logic [7:0]         computed_crc;
    logic [7:0]         received_crc;
    logic               crc_ok;
  } out_item_t;

  // Reflected CRC-8, polynomial 0x31, one full byte per call.
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] r;
    logic       fb;
    r = crc;
    for (int i = 0; i < 8; i++) begin
      fb = r[0] ^ data[i];
      r  = {1'b0, r[7:1]};
      if (fb) begin
        r = r ^ CrcFeedback;
      end
    end
    return r;
  endfunction

  // Keep the fraction bits that the resolution defines, clear the rest.
  function automatic logic [11:0] fraction_mask(input logic [1:0] res);
    logic [11:0] m;
    case (res)
      RES_9BIT:  m = 12'hFF8;
      RES_10BIT: m = 12'hFFC;
      RES_11BIT: m = 12'hFFE;
      RES_12BIT: m = 12'hFFF;
      default:   m = 12'hFFF;
    endcase
    return m;
  endfunction

endpackage

// ===== rtl/tssc_frame.sv =====
// Frame tracking: byte position, running CRC and the kept temperature and resolution bytes.
module tssc_frame (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  tssc_pkg::in_item_t  item,
  output logic                result_valid,
  output tssc_pkg::out_item_t result
);
  import tssc_pkg::*;

  logic [PosWidth-1:0] byte_position;
  logic [PosWidth-1:0] pos;
  logic [7:0]          crc_register;
  logic [7:0]          crc_next;
  logic [7:0]          temp_low_byte;
  logic [7:0]          temp_high_byte;
  logic [1:0]          resolution_bits;
  logic [11:0]         raw;

  always_comb begin
    pos = item.frame_start ? POS_TEMP_LOW : byte_position;
    if (pos > POS_CRC) begin
      pos = POS_TEMP_LOW;
    end
    // byte 0 restarts the CRC from zero
    crc_next = crc8_byte((pos == POS_TEMP_LOW) ? 8'd0 : crc_register, item.byte_value);
  end

  assign result_valid = accept && (pos == POS_CRC);

  always_comb begin
    raw = {temp_high_byte[3:0], temp_low_byte} & fraction_mask(resolution_bits);
    result.temperature_sixteenths = raw;
    result.resolution_code        = resolution_bits;
    result.computed_crc           = crc_register;
    result.received_crc           = item.byte_value;
    result.crc_ok                 = (crc_register == item.byte_value);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= POS_TEMP_LOW;
      crc_register  <= 8'd0;
    end else if (accept) begin
      if (pos == POS_CRC) begin
        byte_position <= POS_TEMP_LOW;
      end else begin
        byte_position <= pos + PosWidth'(1);
        crc_register  <= crc_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (pos == POS_TEMP_LOW) begin
        temp_low_byte <= item.byte_value;
      end
      if (pos == POS_TEMP_HIGH) begin
        temp_high_byte <= item.byte_value;
      end
      if (pos == POS_CONFIG) begin
        resolution_bits <= item.byte_value[ResShift +: 2];
      end
    end
  end

endmodule

// ===== rtl/tssc_out_buf.sv =====
// Output register with a skid stage so the input side keeps moving while a result waits.
module tssc_out_buf (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  tssc_pkg::out_item_t push_item,
  output logic                space,
  output logic                out_valid,
  input  logic                out_ready,
  output tssc_pkg::out_item_t out_item
);
  import tssc_pkg::*;

  logic      skid_valid;
  out_item_t skid_item;
  logic      pop;

  assign space = !skid_valid;
  assign pop   = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || pop) begin
      // advance: skid first, then the new result
      out_valid  <= skid_valid || push;
      skid_valid <= 1'b0;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || pop) begin
      out_item <= skid_valid ? skid_item : push_item;
    end else if (push) begin
      skid_item <= push_item;
    end
  end

endmodule

// ===== rtl/temp_sensor_scratchpad_checker_core.sv =====
// Top level of the one-wire temperature sensor scratchpad checker.
// Takes one scratchpad byte per transaction, one per clock cycle when the
// output side keeps up. The CRC-8 over a whole byte is done in the same cycle
// the byte is accepted. Bytes 0 to 7 produce no result; byte 8 produces one
// result transaction carrying the temperature in 1/16 degree (undefined
// fraction bits cleared), the resolution code, the computed and received CRC
// and a match flag. At the edge that accepts byte 8 the result is loaded into
// the output register, offered from the next cycle on, or into the skid stage
// while that register holds one not yet taken. This two-entry output buffer
// lets input continue while a result waits; input stalls only when both
// entries are full. frame_start forces a byte to be taken as byte 0.
module temp_sensor_scratchpad_checker_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  tssc_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output tssc_pkg::out_item_t out_item
);
  import tssc_pkg::*;

  logic      accept;
  logic      result_valid;
  out_item_t result;
  logic      space;

  assign in_ready = space;
  assign accept   = in_valid && in_ready;

  tssc_frame u_frame (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .item         (in_item),
    .result_valid (result_valid),
    .result       (result)
  );

  tssc_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (result_valid),
    .push_item (result),
    .space     (space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

// ===== tb/tb_temp_sensor_scratchpad_checker_core.sv =====
// Self-checking testbench for the scratchpad checker: byte stimulus, readout prediction, checks.
`timescale 1ns / 100ps

module tb_temp_sensor_scratchpad_checker_core;
  import tssc_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int ByteTarget = 1350;
  localparam int LongHold   = 400;

  // Tracks frame position, running CRC and stored bytes; queues the readout each byte 8 owes.
  class frame_scoreboard;
    out_item_t   pending_readouts[$];
    logic [3:0]  next_pos;
    logic [7:0]  crc_acc;
    logic [7:0]  temp_lo;
    logic [7:0]  temp_hi;
    logic [1:0]  res_code;
    int          mismatches;
    int          readouts_checked;
    int          crc_matches;

    function new();
      next_pos         = POS_TEMP_LOW;
      crc_acc          = '0;
      temp_lo          = '0;
      temp_hi          = '0;
      res_code         = '0;
      mismatches       = 0;
      readouts_checked = 0;
      crc_matches      = 0;
    endfunction

    // Fold the whole byte in first, then shift out eight bits.
    static function logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] r;
      r = crc ^ data;
      for (int k = 0; k < 8; k++) begin
        r = r[0] ? ((r >> 1) ^ CrcFeedback) : (r >> 1);
      end
      return r;
    endfunction

    function void flag(input string msg);
      mismatches++;
      if (mismatches <= 10) begin
        $display("[%0t] ERROR: %s", $realtime, msg);
      end
    endfunction

    function void take_byte(input in_item_t item);
      logic [3:0]  pos;
      logic [11:0] raw;
      int          drop;
      out_item_t   readout;
      pos = item.frame_start ? POS_TEMP_LOW : next_pos;
      if (pos > POS_CRC) begin
        pos = POS_TEMP_LOW;
      end
      if (pos == POS_CRC) begin
        raw  = {temp_hi[3:0], temp_lo};
        drop = 3 - int'(res_code);
        readout.temperature_sixteenths = (raw >> drop) << drop;
        readout.resolution_code        = res_code;
        readout.computed_crc           = crc_acc;
        readout.received_crc           = item.byte_value;
        readout.crc_ok                 = (crc_acc == item.byte_value);
        pending_readouts.push_back(readout);
        next_pos = POS_TEMP_LOW;
      end else begin
        crc_acc = crc_byte((pos == POS_TEMP_LOW) ? 8'h00 : crc_acc, item.byte_value);
        if (pos == POS_TEMP_LOW) begin
          temp_lo = item.byte_value;
        end else if (pos == POS_TEMP_HIGH) begin
          temp_hi = item.byte_value;
        end else if (pos == POS_CONFIG) begin
          res_code = item.byte_value[ResShift +: 2];
        end
        next_pos = pos + 4'd1;
      end
    endfunction

    function void check_readout(input out_item_t got);
      out_item_t want;
      readouts_checked++;
      if (got.crc_ok) begin
        crc_matches++;
      end
      if (pending_readouts.size() == 0) begin
        flag($sformatf("readout with none pending: temp %0d crc %h/%h",
                       got.temperature_sixteenths, got.computed_crc, got.received_crc));
        return;
      end
      want = pending_readouts.pop_front();
      if (got.temperature_sixteenths !== want.temperature_sixteenths ||
          got.resolution_code !== want.resolution_code ||
          got.computed_crc !== want.computed_crc ||
          got.received_crc !== want.received_crc ||
          got.crc_ok !== want.crc_ok) begin
        flag($sformatf({"readout mismatch: temp exp %0d got %0d, res exp %0d got %0d, ",
                        "crc exp %h got %h, rx exp %h got %h, ok exp %b got %b"},
                       want.temperature_sixteenths, got.temperature_sixteenths,
                       want.resolution_code, got.resolution_code,
                       want.computed_crc, got.computed_crc,
                       want.received_crc, got.received_crc,
                       want.crc_ok, got.crc_ok));
      end
    endfunction
  endclass

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  frame_scoreboard scoreboard = new();
  int  bytes_sent  = 0;
  int  frames_sent = 0;
  int  cycle_count = 0;
  bit  tx_burst    = 1'b0;
  bit  rx_burst    = 1'b0;

  temp_sensor_scratchpad_checker_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  always #6 clk = ~clk;

  initial begin : watchdog
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TEST FAILED");
    $finish;
  end

  // Offer one byte, hold it until accepted, then note it.
  task automatic send_byte(input logic [7:0] value, input logic start);
    int       gap;
    in_item_t item;
    item.byte_value  = value;
    item.frame_start = start;
    gap = tx_burst ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= item;
    do @(posedge clk); while (!in_ready);
    scoreboard.take_byte(item);
    bytes_sent++;
    if ($urandom_range(0, 63) == 0) begin
      tx_burst = !tx_burst;
    end
  endtask

  // Full nine-byte scratchpad; byte 8 carries the true CRC unless corrupted.
  task automatic send_frame(input logic [7:0] lo, input logic [7:0] hi, input logic [7:0] cfg,
                            input logic start, input logic corrupt);
    logic [7:0] pad [8];
    logic [7:0] crc;
    crc = 8'h00;
    for (int i = 0; i < 8; i++) begin
      pad[i] = 8'($urandom);
    end
    pad[POS_TEMP_LOW]  = lo;
    pad[POS_TEMP_HIGH] = hi;
    pad[POS_CONFIG]    = cfg;
    for (int i = 0; i < 8; i++) begin
      crc = frame_scoreboard::crc_byte(crc, pad[i]);
      send_byte(pad[i], (i == 0) ? start : 1'b0);
    end
    if (corrupt) begin
      crc = crc ^ 8'($urandom_range(1, 255));
    end
    send_byte(crc, 1'b0);
    frames_sent++;
  endtask

  initial begin : result_sink
    int stall;
    bit held;
    held = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      stall = rx_burst ? 0 : $urandom_range(0, 8);
      // Hold off once for a long stretch so the block fills and stalls its input.
      if (!held && scoreboard.readouts_checked == 15) begin
        stall = LongHold;
        held  = 1'b1;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      scoreboard.check_readout(out_item);
      if ($urandom_range(0, 15) == 0) begin
        rx_burst = !rx_burst;
      end
    end
  end

  initial begin : stimulus
    int         kind;
    int         n;
    logic [7:0] hi;
    logic       sgn;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Positive max with non-sign upper bits, 9-bit resolution, good CRC.
    send_frame(8'hFF, 8'h57, {1'b0, RES_9BIT, 5'h1F}, 1'b1, 1'b0);
    // Wrap after byte 8 without a start flag; most negative value, 12-bit, bad CRC.
    send_frame(8'h00, 8'h88, {1'b0, RES_12BIT, 5'h1F}, 1'b0, 1'b1);
    // Abandon a frame after three bytes.
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_frame(8'h80, 8'hFE, {1'b0, RES_10BIT, 5'h1F}, 1'b1, 1'b0);

    while (bytes_sent < ByteTarget) begin
      kind = $urandom_range(0, 99);
      if (kind < 75) begin
        sgn = 1'($urandom);
        hi  = ($urandom_range(0, 1) == 0) ? {{5{sgn}}, 3'($urandom)} : 8'($urandom);
        send_frame(8'($urandom), hi, 8'($urandom), $urandom_range(0, 4) != 0,
                   $urandom_range(0, 3) == 0);
      end else if (kind < 88) begin
        send_byte(8'($urandom), 1'b1);
        n = $urandom_range(1, 7);
        repeat (n) send_byte(8'($urandom), 1'b0);
      end else begin
        n = $urandom_range(1, 4);
        repeat (n) send_byte(8'($urandom), $urandom_range(0, 3) == 0);
      end
    end
    in_valid <= 1'b0;

    while (scoreboard.pending_readouts.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    $display("Sent %0d bytes (%0d whole frames) with restarts, truncations and noise.",
             bytes_sent, frames_sent);
    $display("Checked %0d readouts: %0d CRC matches, %0d CRC mismatches; %0d errors.",
             scoreboard.readouts_checked, scoreboard.crc_matches,
             scoreboard.readouts_checked - scoreboard.crc_matches, scoreboard.mismatches);
    if (scoreboard.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
